/* hw/rtl/p1305_pkg.sv */
// Shared types and constants for the Poly1305 authenticator.
package p1305_pkg;

  localparam int LimbW  = 26;
  localparam int QDepth = 4;
  localparam int QPtrW  = 2;

  localparam logic [1:0] REG_R_LOW    = 2'd0;
  localparam logic [1:0] REG_R_HIGH   = 2'd1;
  localparam logic [1:0] REG_PAD_LOW  = 2'd2;
  localparam logic [1:0] REG_PAD_HIGH = 2'd3;

  // One padded message block on its way from front to back.
  typedef struct packed {
    logic [127:0] msg;
    logic         hibit;
    logic         absorb;
    logic         last;
  } work_t;

endpackage

/* hw/rtl/p1305_front.sv */
// Front end: pads a message block and classifies it for the back end.
module p1305_front
  import p1305_pkg::*;
(
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic [4:0]  byte_count,
  input  logic        last,
  output work_t       work
);

  logic [4:0]   n;
  logic [127:0] data;

  always_comb begin
    n    = (byte_count > 5'd16) ? 5'd16 : byte_count;
    data = {block_high, block_low};
    for (int b = 0; b < 16; b++) begin
      if (5'(b) < n) begin
        work.msg[8*b +: 8] = data[8*b +: 8];
      end else if (5'(b) == n) begin
        work.msg[8*b +: 8] = 8'h01;
      end else begin
        work.msg[8*b +: 8] = 8'h00;
      end
    end
    work.hibit  = (n == 5'd16);
    work.absorb = (n != 5'd0);
    work.last   = last;
  end

endmodule

/* hw/rtl/p1305_fifo.sv */
// Short word queue between the front and back ends.
module p1305_fifo
  import p1305_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t wdata,
  output logic  full,
  input  logic  pop,
  output work_t rdata,
  output logic  empty
);

  work_t          mem [QDepth];
  logic [QPtrW-1:0] wptr;
  logic [QPtrW-1:0] rptr;
  logic [QPtrW:0]   count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (QPtrW+1)'(QDepth));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/p1305_back.sv */
// Back end: multiply-reduce of the accumulator, final reduction and tag output.
module p1305_back
  import p1305_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  work_t        wk,
  input  logic         wk_empty,
  output logic         wk_pop,
  input  logic [127:0] r_key,
  input  logic [127:0] pad,
  output logic [63:0]  tag_low,
  output logic [63:0]  tag_high,
  output logic         out_empty,
  input  logic         out_pop
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_CARRY, S_FIN1, S_FIN2, S_FIN3
  } state_t;

  localparam logic [25:0] LimbMask = 26'h3ffffff;

  state_t      state;
  logic [2:0]  cnt;
  logic        last_q;
  logic [26:0] h [5];
  logic [27:0] a [5];
  logic [63:0] d [5];
  logic [26:0] f [5];
  logic        out_valid;

  logic [25:0] r [5];
  logic [28:0] s [5];
  logic [25:0] m [5];
  logic [28:0] coef [5];
  logic [27:0] a_sel;
  logic [56:0] prod [5];

  logic [63:0] ch [5];
  logic [63:0] cc;
  logic [31:0] k [5];
  logic [31:0] kc;
  logic [31:0] g [5];
  logic [31:0] gc;
  logic        use_g;
  logic [127:0] packed_h;
  logic [127:0] tag_sum;

  assign wk_pop    = (state == S_IDLE) && !wk_empty;
  assign out_empty = !out_valid;

  always_comb begin
    r[0] = r_key[25:0];
    r[1] = r_key[51:26]  & 26'h3ffff03;
    r[2] = r_key[77:52]  & 26'h3ffc0ff;
    r[3] = r_key[103:78] & 26'h3f03fff;
    r[4] = {2'b00, r_key[127:104]} & 26'h00fffff;
    for (int i = 0; i < 5; i++) begin
      s[i] = {r[i], 2'b00} + 29'(r[i]);
    end
    for (int i = 0; i < 4; i++) begin
      m[i] = wk.msg[LimbW*i +: LimbW];
    end
    m[4] = {1'b0, wk.hibit, wk.msg[127:104]};
  end

  // One column of the schoolbook product per cycle.
  always_comb begin
    a_sel = a[cnt];
    for (int i = 0; i < 5; i++) begin
      if (i >= int'(cnt)) begin
        coef[i] = 29'(r[i - int'(cnt)]);
      end else begin
        coef[i] = s[i - int'(cnt) + 5];
      end
      prod[i] = 57'(a_sel) * 57'(coef[i]);
    end
  end

  // Carry propagation after the product.
  always_comb begin
    cc    = d[0] >> LimbW;
    ch[0] = d[0] & 64'(LimbMask);
    for (int i = 1; i < 5; i++) begin
      ch[i] = d[i] + cc;
      cc    = ch[i] >> LimbW;
      ch[i] = ch[i] & 64'(LimbMask);
    end
    ch[0] = ch[0] + cc * 64'd5;
    cc    = ch[0] >> LimbW;
    ch[0] = ch[0] & 64'(LimbMask);
    ch[1] = ch[1] + cc;
  end

  // Final carry and top fold.
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      k[i] = 32'(h[i]);
    end
    for (int i = 0; i < 4; i++) begin
      kc     = k[i] >> LimbW;
      k[i]   = k[i] & 32'(LimbMask);
      k[i+1] = k[i+1] + kc;
    end
    kc   = k[4] >> LimbW;
    k[4] = k[4] & 32'(LimbMask);
    k[0] = k[0] + kc * 32'd5;
    kc   = k[0] >> LimbW;
    k[0] = k[0] & 32'(LimbMask);
    k[1] = k[1] + kc;
  end

  // Trial subtraction of p.
  always_comb begin
    g[0] = 32'(f[0]) + 32'd5;
    gc   = g[0] >> LimbW;
    g[0] = g[0] & 32'(LimbMask);
    for (int i = 1; i < 4; i++) begin
      g[i] = 32'(f[i]) + gc;
      gc   = g[i] >> LimbW;
      g[i] = g[i] & 32'(LimbMask);
    end
    g[4]  = 32'(f[4]) + gc - 32'h0400_0000;
    use_g = !g[4][31];
  end

  always_comb begin
    packed_h = 128'(f[0]) | (128'(f[1]) << 26) | (128'(f[2]) << 52)
             | (128'(f[3]) << 78) | (128'(f[4]) << 104);
    tag_sum  = packed_h + pad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      last_q    <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        h[i] <= '0;
      end
    end else begin
      if (state == S_FIN3 && (!out_valid || out_pop)) begin
        out_valid <= 1'b1;
      end else if (out_pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!wk_empty) begin
            last_q <= wk.last;
            if (wk.absorb) begin
              for (int i = 0; i < 5; i++) begin
                a[i] <= 28'(h[i]) + 28'(m[i]);
                d[i] <= '0;
              end
              cnt   <= '0;
              state <= S_MUL;
            end else if (wk.last) begin
              state <= S_FIN1;
            end
          end
        end
        S_MUL: begin
          for (int i = 0; i < 5; i++) begin
            d[i] <= d[i] + 64'(prod[i]);
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd4) state <= S_CARRY;
        end
        S_CARRY: begin
          for (int i = 0; i < 5; i++) begin
            h[i] <= 27'(ch[i]);
          end
          state <= last_q ? S_FIN1 : S_IDLE;
        end
        S_FIN1: begin
          for (int i = 0; i < 5; i++) begin
            f[i] <= 27'(k[i]);
          end
          state <= S_FIN2;
        end
        S_FIN2: begin
          if (use_g) begin
            for (int i = 0; i < 5; i++) begin
              f[i] <= 27'(g[i]);
            end
          end
          state <= S_FIN3;
        end
        S_FIN3: begin
          if (!out_valid || out_pop) begin
            tag_low   <= tag_sum[63:0];
            tag_high  <= tag_sum[127:64];
            for (int i = 0; i < 5; i++) begin
              h[i] <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/poly1305_mac.sv */
// Top level of the Poly1305 authenticator: key registers, front end, queue, back end.
//
// Each word is one 16-byte message block. A block with a nonzero count passes through
// a dispatch state, the five-multiplier column engine that walks the five accumulator
// limbs one per cycle, and a carry state; a last word then adds the final reduction
// and the pad add. A last word with count 0 goes straight to the final reduction;
// a non-last word with count 0 is dropped. The input queue holds 4 words and the
// finished tag sits in an output register, so push and pop run independently.
module poly1305_mac
  import p1305_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic [4:0]  byte_count,
  input  logic        last,
  input  logic        push,
  output logic        full,
  output logic [63:0] tag_low,
  output logic [63:0] tag_high,
  output logic        empty,
  input  logic        pop
);

  logic [63:0] r_key_low;
  logic [63:0] r_key_high;
  logic [63:0] pad_low;
  logic [63:0] pad_high;

  work_t front_work;
  work_t q_work;
  logic  q_empty;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_key_low  <= '0;
      r_key_high <= '0;
      pad_low    <= '0;
      pad_high   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_R_LOW:    r_key_low  <= cfg_data;
        REG_R_HIGH:   r_key_high <= cfg_data;
        REG_PAD_LOW:  pad_low    <= cfg_data;
        REG_PAD_HIGH: pad_high   <= cfg_data;
        default:      ;
      endcase
    end
  end

  p1305_front u_front (
    .block_low  (block_low),
    .block_high (block_high),
    .byte_count (byte_count),
    .last       (last),
    .work       (front_work)
  );

  p1305_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_work),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_work),
    .empty (q_empty)
  );

  p1305_back u_back (
    .clk       (clk),
    .rst       (rst),
    .wk        (q_work),
    .wk_empty  (q_empty),
    .wk_pop    (q_pop),
    .r_key     ({r_key_high, r_key_low}),
    .pad       ({pad_high, pad_low}),
    .tag_low   (tag_low),
    .tag_high  (tag_high),
    .out_empty (empty),
    .out_pop   (pop)
  );

endmodule
